FILE: rtl/tsli_pkg.sv
`default_nettype none

package tsli_pkg;

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = $clog2(DATA_W);

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_VALID  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BEFORE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_APPEND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_RESULT
    } tsli_state_t;

endpackage

`default_nettype wire

FILE: rtl/tsli_in_if.sv
`default_nettype none

interface tsli_in_if
    import tsli_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [DATA_W-1:0] sample_time;
    logic [DATA_W-1:0] sample_price;
    logic [DATA_W-1:0] query_time;

    modport source (
        output valid, mode, sample_time, sample_price, query_time,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_time, sample_price, query_time,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tsli_out_if.sv
`default_nettype none

interface tsli_out_if
    import tsli_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   price;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, price, status,
        input  ready
    );

    modport sink (
        input  valid, price, status,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tsli_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// upper half of the dividend is below the divisor, so the quotient fits DATA_W.
module tsli_div
    import tsli_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*DATA_W-1:0]   dividend,
    input  wire logic [DATA_W-1:0]     divisor,
    output logic                       done,
    output logic [DATA_W-1:0]          quotient
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] low_reg, low_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              take;

    always_comb
    begin
        shifted     = {rem_reg, low_reg[DATA_W-1]};
        diff        = shifted - {1'b0, div_reg};
        take        = (shifted >= {1'b0, div_reg});
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        div_next    = div_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = STEP_W'(DATA_W - 1);
            rem_next    = dividend[2*DATA_W-1:DATA_W];
            low_next    = dividend[DATA_W-1:0];
            div_next    = divisor;
        end
        else if (active_reg)
        begin
            rem_next = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            low_next = {low_reg[DATA_W-2:0], take};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

`default_nettype wire

FILE: rtl/time_series_linear_interp.sv
`default_nettype none

// Channel  Role   Payload                                         Handshake
// req      sink   mode, sample_time, sample_price, query_time     valid/ready
// rsp      source price, status                                   valid/ready
//
// One request is worked on at a time. An append passes through S_APPEND and
// S_RESULT before its response goes to the output register. A query scans the
// sample memory from the newest entry downward, one entry per cycle with
// registered read data, and then passes through S_RESULT. Interpolation adds
// the S_MUL state and the divider in S_DIV before S_RESULT.
// Reset clears the sample count and the control state; the memories need no
// clearing. A stalled response is held in the output register while the next
// request is taken, and that request's response waits until the register frees.

module time_series_linear_interp
    import tsli_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsli_in_if.sink    req,
    tsli_out_if.source rsp
);

    // Sample memories, one write port and one registered read port each.
    logic [DATA_W-1:0] time_mem  [DEPTH];
    logic [DATA_W-1:0] price_mem [DEPTH];

    tsli_state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DATA_W-1:0]   q_reg, q_next;
    logic [DATA_W-1:0]   st_time_reg, st_time_next;
    logic [DATA_W-1:0]   st_price_reg, st_price_next;
    logic [ADDR_W-1:0]   issue_addr_reg, issue_addr_next;
    logic                issue_active_reg, issue_active_next;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_idx_reg;
    logic [DATA_W-1:0]   time_rd_reg;
    logic [DATA_W-1:0]   price_rd_reg;
    logic [DATA_W-1:0]   hi_time_reg, hi_time_next;
    logic [DATA_W-1:0]   hi_price_reg, hi_price_next;
    logic [DATA_W-1:0]   lo_price_reg, lo_price_next;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   mag_reg, mag_next;
    logic [DATA_W-1:0]   num_reg, num_next;
    logic [DATA_W-1:0]   den_reg, den_next;
    logic [DATA_W-1:0]   res_price_reg, res_price_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_price_reg, out_price_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Control outputs of the state machine.
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic accept;
    logic out_free;
    logic not_full;

    // Scan decision on the entry whose read data is present this cycle.
    logic                top_entry;
    logic                bottom_entry;
    logic                scan_done;
    logic                scan_interp;
    logic [DATA_W-1:0]   scan_price;
    logic [STATUS_W-1:0] scan_status;

    logic [2*DATA_W-1:0] product;
    logic                div_done;
    logic [DATA_W-1:0]   quotient;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign not_full = (count_reg < CNT_W'(DEPTH));

    // The scan follows the bracketing rule exactly, which also covers samples
    // that were appended out of time order. Coming from the newest entry, the
    // first older entry at or below the query time sets the upper bracket to
    // the entry just above it.
    always_comb
    begin
        top_entry    = ({1'b0, rd_idx_reg} == (count_reg - CNT_W'(1)));
        bottom_entry = (rd_idx_reg == '0);
        scan_done    = 1'b0;
        scan_interp  = 1'b0;
        scan_price   = '0;
        scan_status  = ST_VALID;
        if (state_reg == S_SCAN && rd_valid_reg)
        begin
            if (top_entry)
            begin
                // A single sample answers by itself or flags the query as early.
                if (bottom_entry)
                begin
                    scan_done = 1'b1;
                    if (time_rd_reg > q_reg)
                    begin
                        scan_status = ST_BEFORE;
                    end
                    else
                    begin
                        scan_price = price_rd_reg;
                    end
                end
            end
            else if (time_rd_reg <= q_reg)
            begin
                scan_done = 1'b1;
                if (hi_time_reg <= q_reg)
                begin
                    scan_price = hi_price_reg;
                end
                else if (time_rd_reg == hi_time_reg || q_reg == time_rd_reg)
                begin
                    scan_price = price_rd_reg;
                end
                else
                begin
                    scan_interp = 1'b1;
                end
            end
            else if (bottom_entry)
            begin
                scan_done   = 1'b1;
                scan_status = ST_BEFORE;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == MODE_APPEND)
                    begin
                        state_next = S_APPEND;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_APPEND:
            begin
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = scan_interp ? S_MUL : S_RESULT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        rd_en     = (state_reg == S_SCAN) && issue_active_reg;
        wr_en     = (state_reg == S_APPEND) && not_full;
        div_start = (state_reg == S_MUL);
    end

    // The multiplier feeds the divider's loading registers directly.
    assign product = mag_reg * num_reg;

    tsli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Datapath next values.
    always_comb
    begin
        count_next        = count_reg;
        q_next            = q_reg;
        st_time_next      = st_time_reg;
        st_price_next     = st_price_reg;
        issue_addr_next   = issue_addr_reg;
        issue_active_next = issue_active_reg;
        hi_time_next      = hi_time_reg;
        hi_price_next     = hi_price_reg;
        lo_price_next     = lo_price_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        res_price_next    = res_price_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_price_next    = out_price_reg;
        out_status_next   = out_status_reg;

        if (accept)
        begin
            q_next            = req.query_time;
            st_time_next      = req.sample_time;
            st_price_next     = req.sample_price;
            issue_addr_next   = ADDR_W'(count_reg - CNT_W'(1));
            issue_active_next = 1'b1;
            res_price_next    = '0;
            res_status_next   = ST_EMPTY;
        end

        if (state_reg == S_APPEND)
        begin
            if (not_full)
            begin
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_APPEND;
            end
            else
            begin
                res_status_next = ST_FULL;
            end
        end

        if (rd_en)
        begin
            if (issue_addr_reg == '0)
            begin
                issue_active_next = 1'b0;
            end
            else
            begin
                issue_addr_next = issue_addr_reg - ADDR_W'(1);
            end
        end

        if (state_reg == S_SCAN && rd_valid_reg)
        begin
            hi_time_next  = time_rd_reg;
            hi_price_next = price_rd_reg;
            if (scan_done)
            begin
                issue_active_next = 1'b0;
                res_price_next    = scan_price;
                res_status_next   = scan_status;
            end
            // Interpolation works on the magnitude of the price step and
            // applies its sign afterward, so the quotient truncates toward zero.
            lo_price_next = price_rd_reg;
            neg_next      = (hi_price_reg < price_rd_reg);
            mag_next      = (hi_price_reg < price_rd_reg) ? price_rd_reg - hi_price_reg
                                                          : hi_price_reg - price_rd_reg;
            num_next      = q_reg - time_rd_reg;
            den_next      = hi_time_reg - time_rd_reg;
        end

        if (state_reg == S_DIV && div_done)
        begin
            res_price_next  = neg_reg ? lo_price_reg - quotient : lo_price_reg + quotient;
            res_status_next = ST_VALID;
        end

        if (state_reg == S_RESULT && out_free)
        begin
            out_valid_next  = 1'b1;
            out_price_next  = res_price_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            issue_active_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            issue_active_reg <= issue_active_next;
            rd_valid_reg     <= rd_en;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        st_time_reg    <= st_time_next;
        st_price_reg   <= st_price_next;
        issue_addr_reg <= issue_addr_next;
        hi_time_reg    <= hi_time_next;
        hi_price_reg   <= hi_price_next;
        lo_price_reg   <= lo_price_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        res_price_reg  <= res_price_next;
        res_status_reg <= res_status_next;
        out_price_reg  <= out_price_next;
        out_status_reg <= out_status_next;
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[count_reg[ADDR_W-1:0]]  <= st_time_reg;
            price_mem[count_reg[ADDR_W-1:0]] <= st_price_reg;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            time_rd_reg  <= time_mem[issue_addr_reg];
            price_rd_reg <= price_mem[issue_addr_reg];
            rd_idx_reg   <= issue_addr_reg;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.price  = out_price_reg;
    assign rsp.status = out_status_reg;

endmodule

`default_nettype wire

FILE: tb/time_series_linear_interp_test.sv
`default_nettype none

// Checks the time series interpolator through its request and response channels.
//
// Every accepted request is run through a predictor that keeps its own copy of
// the sample store. The expected response goes into a queue. A monitor
// compares each accepted response with the oldest entry in that queue, one
// field at a time.
//
// The tests run in this order, because reset is applied only once and the store
// only ever grows:
//   - queries against an empty store;
//   - a short hand-built series: a query before the first sample, on a sample,
//     on a run of equal times, on a rising and a falling segment, after the
//     newest sample, and at the largest time;
//   - a long random series. Most appends follow time order with random prices.
//     Some times are random, which makes the series out of order. Queries aim
//     between neighbors, on samples, before the first sample and after the
//     newest one, with some fully random times mixed in;
//   - a few queries at or below the oldest sample and at the largest time.
// Both the request and the response side pause for random stretches, most of
// them short. Some stretches of the run have no pauses at all.

module time_series_linear_interp_test;

    import tsli_pkg::*;

    // The limit allows several times the longest query, one that scans all
    // DEPTH entries and then divides, together with the longest pause that
    // either side may add.
    localparam int WATCHDOG_LIMIT = 4 * (DEPTH + 160);
    localparam int DRAIN_CYCLES   = 50;
    localparam int RANDOM_ITEMS   = 117;

    typedef struct packed {
        logic [DATA_W-1:0]   price;
        logic [STATUS_W-1:0] status;
    } reply_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tsli_in_if  req();
    tsli_out_if rsp();

    time_series_linear_interp uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // This is the testbench's own view of the sample store. Entries at and
    // above known_count are never read.
    logic [DATA_W-1:0] known_times  [DEPTH];
    logic [DATA_W-1:0] known_prices [DEPTH];
    int unsigned       known_count = 0;

    reply_t            due_replies [$];
    reply_t            head_reply;
    int unsigned       fail_count  = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       ready_hold  = 0;
    logic [DATA_W-1:0] last_stamp  = '0;
    // When this is set, neither side pauses.
    bit                steady      = 1'b0;

    // Picks a pause length. Most pauses are zero or short. A few are long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 16);
    endfunction

    // This is a linear blend between two samples. The slope magnitude times
    // the offset is exact in 64 bits. The quotient is truncated, so the result
    // stays between the two prices.
    function automatic logic [DATA_W-1:0] blend_price(
        input logic [DATA_W-1:0] p1,
        input logic [DATA_W-1:0] p2,
        input logic [DATA_W-1:0] t1,
        input logic [DATA_W-1:0] t2,
        input logic [DATA_W-1:0] q
    );
        logic [DATA_W-1:0] span32;
        logic [DATA_W-1:0] offset32;
        logic [DATA_W-1:0] rise32;
        logic [63:0]       quo;
        span32   = t2 - t1;
        offset32 = q - t1;
        if (span32 == '0)
            return p1;
        if (p2 >= p1)
        begin
            rise32 = p2 - p1;
            quo    = ({32'd0, rise32} * {32'd0, offset32}) / {32'd0, span32};
            return p1 + quo[DATA_W-1:0];
        end
        rise32 = p1 - p2;
        quo    = ({32'd0, rise32} * {32'd0, offset32}) / {32'd0, span32};
        return p1 - quo[DATA_W-1:0];
    endfunction

    // Applies one accepted request to the store copy and returns the response
    // that the block must give for it.
    function automatic reply_t predict_reply(
        input logic              mode,
        input logic [DATA_W-1:0] sample_time,
        input logic [DATA_W-1:0] sample_price,
        input logic [DATA_W-1:0] query_time
    );
        reply_t      r;
        int unsigned hi;
        int unsigned lo;
        r.price = '0;
        if (mode == MODE_APPEND)
        begin
            if (known_count < DEPTH)
            begin
                known_times[known_count]  = sample_time;
                known_prices[known_count] = sample_price;
                known_count++;
                r.status = ST_APPEND;
            end
            else
            begin
                r.status = ST_FULL;
            end
            return r;
        end
        if (known_count == 0)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        // Walk back from the newest sample until the one below it is not later
        // than the query.
        hi = known_count - 1;
        while (hi > 0 && known_times[hi-1] > query_time)
            hi--;
        if (hi == 0)
        begin
            lo = 0;
            if (known_times[0] > query_time)
            begin
                r.status = ST_BEFORE;
                return r;
            end
        end
        else if (known_times[hi] <= query_time)
        begin
            lo = hi;
        end
        else
        begin
            lo = hi - 1;
        end
        r.status = ST_VALID;
        if (known_times[lo] == known_times[hi] || query_time == known_times[lo])
            r.price = known_prices[lo];
        else
            r.price = blend_price(known_prices[lo], known_prices[hi],
                                  known_times[lo], known_times[hi], query_time);
        return r;
    endfunction

    // Presents one request, after a random pause, and waits for it to be
    // accepted. The task returns at the next falling edge with valid still
    // high. This way a request that follows at once does not lower valid and
    // raise it again in the same step.
    task automatic send_request(
        input logic              mode,
        input logic [DATA_W-1:0] sample_time,
        input logic [DATA_W-1:0] sample_price,
        input logic [DATA_W-1:0] query_time
    );
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.mode         <= mode;
        req.sample_time  <= sample_time;
        req.sample_price <= sample_price;
        req.query_time   <= query_time;
        req.valid        <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        due_replies.push_back(predict_reply(mode, sample_time, sample_price, query_time));
        @(negedge clk);
    endtask

    // On an append, the query time is noise that the block must ignore.
    task automatic append_sample(input logic [DATA_W-1:0] stamp,
                                 input logic [DATA_W-1:0] price);
        send_request(MODE_APPEND, stamp, price, $urandom);
    endtask

    // On a query, the sample fields are noise that the block must ignore.
    task automatic ask_price(input logic [DATA_W-1:0] q);
        send_request(MODE_QUERY, $urandom, $urandom, q);
    endtask

    task automatic test_empty_store();
        ask_price('0);
        ask_price('1);
        ask_price($urandom);
    endtask

    // This is a small series with a run of equal times, a rising segment, a
    // falling segment and a price of all ones.
    task automatic test_bracketing();
        append_sample(32'd10,   32'h0001_0000);
        append_sample(32'd20,   32'h0005_0000);
        append_sample(32'd20,   32'h0007_0000);
        append_sample(32'd40,   32'h0002_8000);
        append_sample(32'd1000, 32'hFFFF_FFFF);
        ask_price(32'd0);
        ask_price(32'd9);
        ask_price(32'd10);
        ask_price(32'd15);
        ask_price(32'd20);
        ask_price(32'd30);
        ask_price(32'd39);
        ask_price(32'd40);
        ask_price(32'd999);
        ask_price(32'd1000);
        ask_price(32'd5000);
        ask_price(32'hFFFF_FFFF);
        last_stamp = 32'd1000;
    endtask

    // Picks a query time that does something useful against the current
    // store. The store always holds at least two samples here.
    function automatic logic [DATA_W-1:0] pick_query_time();
        int unsigned       sel;
        int unsigned       idx;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        sel = $urandom_range(9, 0);
        if (sel < 5)
        begin
            idx = $urandom_range(known_count - 2, 0);
            lo  = known_times[idx];
            hi  = known_times[idx+1];
            return (hi > lo) ? lo + $urandom_range(hi - lo, 0) : lo;
        end
        if (sel < 7)
            return known_times[$urandom_range(known_count - 1, 0)];
        if (sel == 7)
            return $urandom;
        if (sel == 8)
            return (known_times[0] != '0) ? $urandom_range(known_times[0] - 1, 0) : '0;
        hi = known_times[known_count-1];
        return (hi > 32'hFFFF_F000) ? hi : hi + $urandom_range(1000, 0);
    endfunction

    task automatic test_random_series();
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] stamp;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                steady = ($urandom_range(3, 0) == 0);
            if ($urandom_range(99, 0) < 35)
            begin
                // Most appends keep time order. Small steps give runs of equal
                // times. A random time now and then breaks the order.
                if ($urandom_range(9, 0) == 0)
                begin
                    stamp = $urandom;
                end
                else
                begin
                    step = ($urandom_range(3, 0) == 0) ? $urandom_range(2, 0)
                                                       : $urandom_range(1 << 20, 1);
                    stamp = (last_stamp > 32'hFFFF_FFFF - step) ? $urandom
                                                                : last_stamp + step;
                end
                last_stamp = stamp;
                append_sample(stamp, $urandom);
            end
            else
            begin
                ask_price(pick_query_time());
            end
        end
        steady = 1'b0;
    endtask

    // These queries aim at or below the oldest sample, and at the largest time.
    task automatic test_long_scans();
        ask_price(32'd0);
        ask_price(known_times[0]);
        ask_price(32'hFFFF_FFFF);
    endtask

    // The response side pauses for random stretches and then stays ready for
    // a short random run.
    always @(negedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold--;
        end
        else if (rsp.ready)
        begin
            ready_hold = pick_gap();
            if (ready_hold != 0)
            begin
                rsp.ready <= 1'b0;
                ready_hold--;
            end
        end
        else
        begin
            rsp.ready  <= 1'b1;
            ready_hold = $urandom_range(8, 0);
        end
    end

    // Every accepted response must match the oldest expected response.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (due_replies.size() == 0)
            begin
                $error("response with none expected: price %h status %0d",
                       rsp.price, rsp.status);
                fail_count++;
            end
            else
            begin
                head_reply = due_replies.pop_front();
                if (rsp.price !== head_reply.price)
                begin
                    $error("price: expected %h, actual %h", head_reply.price, rsp.price);
                    fail_count++;
                end
                if (rsp.status !== head_reply.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           head_reply.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // The run ends if neither channel moves a request or a response for
    // too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("time_series_linear_interp_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        req.valid        = 1'b0;
        req.mode         = MODE_APPEND;
        req.sample_time  = '0;
        req.sample_price = '0;
        req.query_time   = '0;
        rsp.ready        = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_bracketing();
        test_random_series();
        test_long_scans();

        req.valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("time_series_linear_interp_test: PASS");
        else
            $display("time_series_linear_interp_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/tsli_pkg.sv
rtl/tsli_in_if.sv
rtl/tsli_out_if.sv
rtl/tsli_div.sv
rtl/time_series_linear_interp.sv
tb/time_series_linear_interp_test.sv
